### hw/rtl/dks_pkg.sv
// dks_pkg: shared types and constants of the dose kernel superposition block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dks_pkg;
   localparam int ACC_W = 40;
   localparam int PCT_W = 15;
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_SEED  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;
   localparam logic [2:0] REG_DIM_X = 3'd0;
   localparam logic [2:0] REG_DIM_Y = 3'd1;
   localparam logic [2:0] REG_DIM_Z = 3'd2;
   localparam logic [2:0] REG_KSIZE = 3'd3;
   localparam logic [2:0] REG_KLOW  = 3'd4;

   // commands from controller to datapath
   typedef struct packed {
      logic latch;      // capture request, compute bounds
      logic clr_step;   // clear one grid voxel
      logic clr_start;
      logic load_wr;    // write kernel word
      logic walk_start; // reset walk counters
      logic walk_step;  // issue one read of kernel and grid
      logic acc_wb;     // write back accumulated voxel
      logic rd_issue;   // issue voxel read
      logic div_start;  // start percent divide
      logic rsp_load;   // load response register
   } dks_cmd_type;

   typedef struct packed {
      logic       clr_done;
      logic       walk_last;
      logic       walk_empty;
      logic       div_done;
      logic [1:0] opcode;
   } dks_stat_type;
endpackage
`default_nettype wire

### hw/rtl/dks_if.sv
// dks_req_if / dks_rsp_if / dks_csr_if: valid-ready channels of the block
// depends on dks_pkg
`timescale 1ns / 1ps
`default_nettype none
interface dks_req_if;
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic signed [7:0] pos_x;
   logic signed [7:0] pos_y;
   logic signed [7:0] pos_z;
   logic [15:0]      value_in;
   modport source (output valid, opcode, pos_x, pos_y, pos_z, value_in, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, pos_z, value_in, output ready);
endinterface

interface dks_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dks_pkg::ACC_W-1:0]    raw_dose;
   logic [dks_pkg::PCT_W-1:0]    dose_percent;
   logic                         max_valid;
   logic                         saturated;
   modport source (output valid, raw_dose, dose_percent, max_valid, saturated, input ready);
   modport sink (input valid, raw_dose, dose_percent, max_valid, saturated, output ready);
endinterface

interface dks_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [7:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/dks_divider.sv
// dks_divider: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module dks_divider #(
   parameter int NUM_W = 55,
   parameter int DEN_W = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   // shift one numerator bit into the remainder, subtract if it fits
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

### hw/rtl/dks_datapath.sv
// dks_datapath: grid and kernel memories, walk counters, accumulator, percent
// depends on dks_pkg, dks_divider
`timescale 1ns / 1ps
`default_nettype none
module dks_datapath #(
   parameter int GRID_MAX   = 64,
   parameter int KERNEL_MAX = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dks_pkg::dks_cmd_type      cmd,
   output dks_pkg::dks_stat_type          stat,
   input  wire logic [1:0]                req_opcode,
   input  wire logic signed [7:0]         req_pos_x,
   input  wire logic signed [7:0]         req_pos_y,
   input  wire logic signed [7:0]         req_pos_z,
   input  wire logic [15:0]               req_value_in,
   input  wire logic                      csr_we,
   input  wire logic [2:0]                csr_index,
   input  wire logic [7:0]                csr_data,
   output logic [dks_pkg::ACC_W-1:0]      rsp_raw_dose,
   output logic [dks_pkg::PCT_W-1:0]      rsp_dose_percent,
   output logic                           rsp_max_valid,
   output logic                           rsp_saturated
);
   localparam int ACC_W = dks_pkg::ACC_W;
   localparam int PCT_W = dks_pkg::PCT_W;
   localparam int GB    = $clog2(GRID_MAX);
   localparam int KB    = $clog2(KERNEL_MAX);
   localparam int GA    = 3 * GB;
   localparam int KA    = 3 * KB;
   localparam int CW    = 10;   // signed coordinate math width
   localparam int NUM_W = ACC_W + 15;
   localparam logic [ACC_W-1:0] FULL = '1;

   logic [ACC_W-1:0] grid_mem [2**GA];
   logic [15:0]      kern_mem [2**KA];

   // configuration
   logic [6:0] dimx_ff, dimy_ff, dimz_ff;
   logic [5:0] ksize_ff, klow_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dimx_ff  <= 7'd64;
         dimy_ff  <= 7'd64;
         dimz_ff  <= 7'd64;
         ksize_ff <= 6'd32;
         klow_ff  <= 6'h30;
      end else if (csr_we) begin
         unique case (csr_index)
            dks_pkg::REG_DIM_X: dimx_ff  <= csr_data[6:0];
            dks_pkg::REG_DIM_Y: dimy_ff  <= csr_data[6:0];
            dks_pkg::REG_DIM_Z: dimz_ff  <= csr_data[6:0];
            dks_pkg::REG_KSIZE: ksize_ff <= csr_data[5:0];
            dks_pkg::REG_KLOW:  klow_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // clamp registers to legal ranges
   function automatic logic signed [CW-1:0] clamp_dim(input logic [6:0] v, input int hi);
      logic signed [CW-1:0] r;
      r = signed'(CW'(v));
      if (r < 1) r = 1;
      if (r > CW'(hi)) r = CW'(hi);
      return r;
   endfunction
   logic signed [CW-1:0] dx, dy, dz, ks, kl;
   always_comb begin
      dx = clamp_dim(dimx_ff, GRID_MAX);
      dy = clamp_dim(dimy_ff, GRID_MAX);
      dz = clamp_dim(dimz_ff, GRID_MAX);
      ks = clamp_dim({1'b0, ksize_ff}, KERNEL_MAX);
      kl = CW'(signed'(klow_ff));
      if (kl < CW'(1 - KERNEL_MAX)) kl = CW'(1 - KERNEL_MAX);
      if (kl > 0) kl = '0;
   end

   // latched request
   logic [1:0]           op_ff;
   logic signed [CW-1:0] px_ff, py_ff, pz_ff;
   logic [15:0]          val_ff;
   logic signed [CW-1:0] lx_ff, ly_ff, lz_ff;
   logic signed [CW-1:0] ax_ff, bx_ff, ay_ff, by_ff, az_ff, bz_ff;
   logic                 inside_ff, empty_ff;

   function automatic logic signed [CW-1:0] lo_clip(input logic signed [CW-1:0] lo);
      return (lo < 0) ? -lo : '0;
   endfunction
   function automatic logic signed [CW-1:0] hi_clip(input logic signed [CW-1:0] lo,
         input logic signed [CW-1:0] dim, input logic signed [CW-1:0] k);
      logic signed [CW-1:0] e;
      e = dim - lo;
      return (e > k) ? k : e;
   endfunction

   logic signed [CW-1:0] lx_in, ly_in, lz_in, ax_in, bx_in, ay_in, by_in, az_in, bz_in;
   logic signed [CW-1:0] rx, ry, rz;
   always_comb begin
      rx = CW'(req_pos_x);
      ry = CW'(req_pos_y);
      rz = CW'(req_pos_z);
      lx_in = rx + kl;
      ly_in = ry + kl;
      lz_in = rz + kl;
      ax_in = lo_clip(lx_in);
      ay_in = lo_clip(ly_in);
      az_in = lo_clip(lz_in);
      bx_in = hi_clip(lx_in, dx, ks);
      by_in = hi_clip(ly_in, dy, ks);
      bz_in = hi_clip(lz_in, dz, ks);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= req_opcode;
         px_ff  <= rx;
         py_ff  <= ry;
         pz_ff  <= rz;
         val_ff <= req_value_in;
         lx_ff  <= lx_in;
         ly_ff  <= ly_in;
         lz_ff  <= lz_in;
         ax_ff  <= ax_in;
         bx_ff  <= bx_in;
         ay_ff  <= ay_in;
         by_ff  <= by_in;
         az_ff  <= az_in;
         bz_ff  <= bz_in;
         inside_ff <= (rx >= 0) && (rx < dx) && (ry >= 0) && (ry < dy) &&
                      (rz >= 0) && (rz < dz);
         empty_ff <= (req_value_in == 16'd0) || (ax_in >= bx_in) ||
                     (ay_in >= by_in) || (az_in >= bz_in);
      end
   end

   // clear sweep counter, one voxel per cycle
   logic [GA:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_start) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
   end

   // kernel walk counters
   logic signed [CW-1:0] ix_ff, iy_ff, iz_ff;
   logic                 last_xy, last_xyz;
   always_comb begin
      last_xy  = (ix_ff == bx_ff - 1) && (iy_ff == by_ff - 1);
      last_xyz = last_xy && (iz_ff == bz_ff - 1);
   end
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         ix_ff <= ax_ff;
         iy_ff <= ay_ff;
         iz_ff <= az_ff;
      end else if (cmd.walk_step) begin
         if (ix_ff == bx_ff - 1) begin
            ix_ff <= ax_ff;
            if (iy_ff == by_ff - 1) begin
               iy_ff <= ay_ff;
               iz_ff <= iz_ff + 1'b1;
            end else begin
               iy_ff <= iy_ff + 1'b1;
            end
         end else begin
            ix_ff <= ix_ff + 1'b1;
         end
      end
   end

   // addresses
   logic [CW-1:0] gx, gy, gz;
   logic [GA-1:0] gaddr, kaddr_walk;
   logic [KA-1:0] kaddr;
   always_comb begin
      gx = lx_ff + ix_ff;
      gy = ly_ff + iy_ff;
      gz = lz_ff + iz_ff;
      gaddr = {gz[GB-1:0], gy[GB-1:0], gx[GB-1:0]};
      if (cmd.rd_issue) gaddr = {pz_ff[GB-1:0], py_ff[GB-1:0], px_ff[GB-1:0]};
      kaddr = {iz_ff[KB-1:0], iy_ff[KB-1:0], ix_ff[KB-1:0]};
      kaddr_walk = gaddr;
   end

   // memory ports, registered read data
   logic [ACC_W-1:0] grid_q_ff;
   logic [15:0]      kern_q_ff;
   logic [GA-1:0]    wb_addr_ff;
   logic [ACC_W:0]   sum;
   logic [ACC_W-1:0] sum_sat;
   logic             load_ok;
   always_comb begin
      sum     = {1'b0, grid_q_ff} + ((ACC_W + 1)'(kern_q_ff) * (ACC_W + 1)'(val_ff));
      sum_sat = sum[ACC_W] ? FULL : sum[ACC_W-1:0];
      load_ok = (px_ff >= 0) && (px_ff < KERNEL_MAX) && (py_ff >= 0) &&
                (py_ff < KERNEL_MAX) && (pz_ff >= 0) && (pz_ff < KERNEL_MAX);
   end
   always_ff @(posedge clock) begin
      if (cmd.clr_step) grid_mem[clr_ff[GA-1:0]] <= '0;
      else if (cmd.acc_wb) grid_mem[wb_addr_ff] <= sum_sat;
      if (cmd.walk_step || cmd.rd_issue) begin
         grid_q_ff  <= grid_mem[kaddr_walk];
         wb_addr_ff <= kaddr_walk;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok)
         kern_mem[{pz_ff[KB-1:0], py_ff[KB-1:0], px_ff[KB-1:0]}] <= val_ff;
      if (cmd.walk_step) kern_q_ff <= kern_mem[kaddr];
   end

   // running maximum and saturation flag
   logic [ACC_W-1:0] max_ff;
   logic             sat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         if (cmd.clr_start) max_ff <= '0;
         else if (cmd.acc_wb && sum_sat > max_ff) max_ff <= sum_sat;
         if (cmd.acc_wb && sum[ACC_W]) sat_ff <= 1'b1;
      end
   end

   // percent divide: raw * 25600 / max
   logic [NUM_W-1:0] num, quo;
   logic             div_done;
   assign num = NUM_W'(grid_q_ff) * NUM_W'(25600);
   dks_divider #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (max_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // response register
   logic [ACC_W-1:0] raw_ff;
   logic [PCT_W-1:0] pct_ff;
   logic [ACC_W-1:0] raw_v;
   logic [PCT_W-1:0] pct_v;
   always_comb begin
      raw_v = '0;
      pct_v = '0;
      if (op_ff == dks_pkg::OP_READ && inside_ff) begin
         raw_v = grid_q_ff;
         if (max_ff != '0) pct_v = (quo > NUM_W'(15'h7FFF)) ? 15'h7FFF : quo[PCT_W-1:0];
         else pct_v = (grid_q_ff > ACC_W'(15'h7FFF)) ? 15'h7FFF : grid_q_ff[PCT_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         raw_ff <= raw_v;
         pct_ff <= pct_v;
      end
   end

   assign rsp_raw_dose     = raw_ff;
   assign rsp_dose_percent = pct_ff;
   assign rsp_max_valid    = (max_ff != '0);
   assign rsp_saturated    = sat_ff;

   always_comb begin
      stat.clr_done   = (clr_ff == (GA + 1)'(2**GA - 1));
      stat.walk_last  = last_xyz;
      stat.walk_empty = empty_ff;
      stat.div_done   = div_done;
      stat.opcode     = op_ff;
   end

   // saturation flag never falls outside reset
   assert property (@(posedge clock) disable iff (reset) $past(sat_ff) |-> sat_ff)
      else $error("saturation flag dropped");
   // clear and write-back never coincide
   assert property (@(posedge clock) disable iff (reset) !(cmd.clr_step && cmd.acc_wb))
      else $error("clear and accumulate collide");
   // maximum only grows except on clear
   assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.clr_start) && !$past(reset) |-> max_ff >= $past(max_ff))
      else $error("maximum decreased");
endmodule
`default_nettype wire

### hw/rtl/dks_ctrl.sv
// dks_ctrl: sequencer for clear, load, seed add and read requests
// depends on dks_pkg
`timescale 1ns / 1ps
`default_nettype none
module dks_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output dks_pkg::dks_cmd_type      cmd,
   input  wire dks_pkg::dks_stat_type stat
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CLEAR, S_WALK, S_DRAIN, S_RDWAIT, S_DIV, S_RESP, S_INIT
   } state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      wb_ff, wb_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      wb_in        = 1'b0;
      cmd          = '0;
      cmd.acc_wb   = wb_ff;
      req_ready    = (state_ff == S_IDLE) && !rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         // zero the grid after reset, no response
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid && req_ready) begin
            cmd.latch = 1'b1;
            state_in  = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.opcode)
               dks_pkg::OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in = S_CLEAR;
               end
               dks_pkg::OP_LOAD: begin
                  cmd.load_wr = 1'b1;
                  state_in = S_RESP;
               end
               dks_pkg::OP_SEED: begin
                  cmd.walk_start = 1'b1;
                  state_in = stat.walk_empty ? S_RESP : S_WALK;
               end
               default: begin
                  cmd.rd_issue = 1'b1;
                  state_in = S_RDWAIT;
               end
            endcase
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = S_RESP;
         end
         // read-modify-write: each read is written back in the next cycle
         S_WALK: begin
            if (!wb_ff) begin
               cmd.walk_step = 1'b1;
               wb_in = 1'b1;
               if (stat.walk_last) state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_RESP;
         S_RDWAIT: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: if (stat.div_done) state_in = S_RESP;
         S_RESP: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         wb_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_ff        <= wb_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a request is taken only with the response slot empty
   assert property (@(posedge clock) disable iff (reset) req_valid && req_ready |-> !rsp_valid)
      else $error("request accepted over pending response");
   // response held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped");
   // write-back always follows a walk read
   assert property (@(posedge clock) disable iff (reset) cmd.walk_step |=> cmd.acc_wb)
      else $error("missing write-back");
endmodule
`default_nettype wire

### hw/rtl/dose_kernel_superposition_top.sv
// dose_kernel_superposition_top: top level of the dose kernel superposition block
// depends on dks_pkg, dks_if, dks_ctrl, dks_datapath
//
// One request at a time. Load kernel writes one kernel word. Read voxel runs the
// bit-serial percent divider (55 steps). Add seed reads and writes back each
// overlapped voxel in turn, a single-port grid memory read-modify-write, for up
// to a full 32^3 kernel. Clear sweeps all GRID_MAX^3 voxels, one voxel per
// cycle. After reset the same sweep zeroes the grid before the first request is
// taken.
// Response occupies an output register; next request is taken once it is consumed.
`timescale 1ns / 1ps
`default_nettype none
module dose_kernel_superposition_top #(
   parameter int GRID_MAX   = 64,
   parameter int KERNEL_MAX = 32
) (
   input wire logic clock,
   input wire logic reset,
   dks_req_if.sink   req,
   dks_rsp_if.source rsp,
   dks_csr_if.sink   csr
);
   dks_pkg::dks_cmd_type  cmd;
   dks_pkg::dks_stat_type stat;

   assign csr.ready = 1'b1;

   dks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   dks_datapath #(.GRID_MAX(GRID_MAX), .KERNEL_MAX(KERNEL_MAX)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req.opcode),
      .req_pos_x        (req.pos_x),
      .req_pos_y        (req.pos_y),
      .req_pos_z        (req.pos_z),
      .req_value_in     (req.value_in),
      .csr_we           (csr.valid),
      .csr_index        (csr.index),
      .csr_data         (csr.data),
      .rsp_raw_dose     (rsp.raw_dose),
      .rsp_dose_percent (rsp.dose_percent),
      .rsp_max_valid    (rsp.max_valid),
      .rsp_saturated    (rsp.saturated)
   );
endmodule
`default_nettype wire
